// ===== rtl/core/async_hdlc_tx_framer_macros.svh =====
// Assertion macros shared by the async HDLC transmit framer RTL.
`ifndef ASYNC_HDLC_TX_FRAMER_MACROS_SVH
`define ASYNC_HDLC_TX_FRAMER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define AHTF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define AHTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ahtf_pkg.sv =====
// Shared types, constants and CRC function of the async HDLC transmit framer.
`timescale 1ns / 1ps
`default_nettype none

package ahtf_pkg;

   // Line octets and FCS constants
   localparam logic [7:0]  FLAG_OCTET = 8'h7e;
   localparam logic [7:0]  ESC_OCTET  = 8'h7d;
   localparam logic [7:0]  ESC_XOR    = 8'h20;
   localparam logic [7:0]  ADDR_OCTET = 8'hff;
   localparam logic [7:0]  CTRL_OCTET = 8'h03;
   localparam logic [15:0] FCS_INIT   = 16'hffff;
   localparam logic [15:0] FCS_POLY   = 16'h8408;
   localparam logic [15:0] LCP_PROTO  = 16'hc021;

   // Queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_MAP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_CTRL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTO_COMP = 2'd2;

   // Operation codes carried from front to back
   typedef logic [2:0] ahtf_op_kind_type;
   localparam ahtf_op_kind_type OP_OPEN   = 3'd0;
   localparam ahtf_op_kind_type OP_BYTE   = 3'd1;
   localparam ahtf_op_kind_type OP_FCS_LO = 3'd2;
   localparam ahtf_op_kind_type OP_FCS_HI = 3'd3;
   localparam ahtf_op_kind_type OP_CLOSE  = 3'd4;

   typedef struct packed {
      ahtf_op_kind_type kind;
      logic [7:0]       value;
      logic             last;   // final op of its input word
   } ahtf_op_type;

   typedef struct packed {
      logic [31:0] esc_map;
      logic        addr_ctrl_compress;
      logic        proto_compress;
   } ahtf_cfg_type;

   // Reflected CRC-16, one byte folded in bit by bit
   function automatic logic [15:0] fcs16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ FCS_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ahtf_if.sv =====
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps
`default_nettype none

interface ahtf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic        last_byte;
   logic [15:0] protocol;

   modport source (output valid, output data_byte, output first_byte,
                   output last_byte, output protocol, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input last_byte, input protocol, output ready);
endinterface

interface ahtf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;

   modport source (output valid, output out_byte, output run_end, input ready);
   modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ahtf_front.sv =====
// Front end: accepts request words and expands each into a list of framing ops.
`timescale 1ns / 1ps
`default_nettype none

module ahtf_front
   import ahtf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ahtf_cfg_type cfg,
   ahtf_req_if.sink          req,
   output ahtf_op_type       push_op,
   output logic              push_valid,
   input  wire logic         push_ready
);

   localparam int NUM_STEPS = 9;
   localparam int STEP_W    = 4;

   localparam logic [STEP_W-1:0] S_OPEN  = 4'd0;
   localparam logic [STEP_W-1:0] S_ADDR  = 4'd1;
   localparam logic [STEP_W-1:0] S_CTRL  = 4'd2;
   localparam logic [STEP_W-1:0] S_PHI   = 4'd3;
   localparam logic [STEP_W-1:0] S_PLO   = 4'd4;
   localparam logic [STEP_W-1:0] S_DATA  = 4'd5;
   localparam logic [STEP_W-1:0] S_FLO   = 4'd6;
   localparam logic [STEP_W-1:0] S_FHI   = 4'd7;
   localparam logic [STEP_W-1:0] S_CLOSE = 4'd8;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [7:0]        data_ff;
   logic              first_ff;
   logic              last_ff;
   logic [15:0]       proto_ff;

   logic [NUM_STEPS-1:0] step_en;
   logic [STEP_W-1:0]    next_step;
   logic                 more_steps;
   logic                 req_fire;
   logic                 push_fire;
   logic                 hdr_en;
   logic                 phi_en;

   // Which steps this word needs
   assign hdr_en = !cfg.addr_ctrl_compress || (proto_ff == LCP_PROTO);
   assign phi_en = !cfg.proto_compress || (proto_ff[15:8] != 8'h00);

   always_comb begin
      step_en          = '0;
      step_en[S_OPEN]  = first_ff;
      step_en[S_ADDR]  = first_ff && hdr_en;
      step_en[S_CTRL]  = first_ff && hdr_en;
      step_en[S_PHI]   = first_ff && phi_en;
      step_en[S_PLO]   = first_ff;
      step_en[S_DATA]  = 1'b1;
      step_en[S_FLO]   = last_ff;
      step_en[S_FHI]   = last_ff;
      step_en[S_CLOSE] = last_ff;
   end

   // Lowest enabled step above the current one
   always_comb begin
      next_step  = step_ff;
      more_steps = 1'b0;
      for (int i = NUM_STEPS - 1; i >= 0; i--) begin
         if (step_en[i] && (STEP_W'(i) > step_ff)) begin
            next_step  = STEP_W'(i);
            more_steps = 1'b1;
         end
      end
   end

   // Op for the current step
   always_comb begin
      push_op.last  = !more_steps;
      push_op.kind  = OP_BYTE;
      push_op.value = data_ff;
      case (step_ff)
         S_OPEN:  push_op.kind = OP_OPEN;
         S_ADDR:  push_op.value = ADDR_OCTET;
         S_CTRL:  push_op.value = CTRL_OCTET;
         S_PHI:   push_op.value = proto_ff[15:8];
         S_PLO:   push_op.value = proto_ff[7:0];
         S_DATA:  push_op.value = data_ff;
         S_FLO:   push_op.kind = OP_FCS_LO;
         S_FHI:   push_op.kind = OP_FCS_HI;
         S_CLOSE: push_op.kind = OP_CLOSE;
         default: push_op.value = data_ff;
      endcase
   end

   assign push_valid = busy_ff;
   assign push_fire  = busy_ff && push_ready;
   assign req.ready  = !busy_ff || (push_fire && !more_steps);
   assign req_fire   = req.valid && req.ready;

   // Sequencer control
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         step_in = req.first_byte ? S_OPEN : S_DATA;
      end else if (push_fire) begin
         if (more_steps) begin
            step_in = next_step;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= S_DATA;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // Held word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         data_ff  <= req.data_byte;
         first_ff <= req.first_byte;
         last_ff  <= req.last_byte;
         proto_ff <= req.protocol;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ahtf_queue.sv =====
// Small op queue decoupling the front end from the octet back end.
`timescale 1ns / 1ps
`default_nettype none

module ahtf_queue
   import ahtf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ahtf_op_type push_op,
   input  wire logic        push_valid,
   output logic             push_ready,
   output ahtf_op_type      pop_op,
   output logic             pop_valid,
   input  wire logic        pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ahtf_op_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_op     = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ahtf_back.sv =====
// Back end: runs FCS, escaping and the output register, one octet per cycle while rsp is not stalled.
`timescale 1ns / 1ps
`default_nettype none

`include "async_hdlc_tx_framer_macros.svh"

module ahtf_back
   import ahtf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ahtf_cfg_type cfg,
   input  wire ahtf_op_type  pop_op,
   input  wire logic         pop_valid,
   output logic              pop_ready,
   ahtf_rsp_if.source        rsp
);

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_end_ff, out_end_in;
   logic        esc_pend_ff, esc_pend_in;
   logic [7:0]  pend_byte_ff, pend_byte_in;
   logic        pend_end_ff, pend_end_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  fcs_hi_ff, fcs_hi_in;

   logic        load_ok;
   logic        take_op;
   logic [15:0] fcs_val;
   logic [7:0]  sel_byte;
   logic        is_data;
   logic        need_esc;
   logic [15:0] crc_upd;

   assign load_ok   = !out_valid_ff || rsp.ready;
   assign take_op   = load_ok && !esc_pend_ff && pop_valid;
   assign pop_ready = take_op;

   // Octet to fold into the FCS and escape
   assign fcs_val = crc_ff ^ FCS_INIT;

   always_comb begin
      is_data  = 1'b1;
      sel_byte = pop_op.value;
      case (pop_op.kind)
         OP_BYTE:   sel_byte = pop_op.value;
         OP_FCS_LO: sel_byte = fcs_val[7:0];
         OP_FCS_HI: sel_byte = fcs_hi_ff;
         OP_OPEN:   is_data = 1'b0;
         OP_CLOSE:  is_data = 1'b0;
         default:   is_data = 1'b0;
      endcase
   end

   assign crc_upd = fcs16_byte(crc_ff, sel_byte);

   // Control characters by map, flag and escape always
   always_comb begin
      if (sel_byte < ESC_XOR) begin
         need_esc = is_data && cfg.esc_map[sel_byte[4:0]];
      end else begin
         need_esc = is_data && ((sel_byte == FLAG_OCTET) || (sel_byte == ESC_OCTET));
      end
   end

   // Output register, pending escaped octet and FCS state
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      esc_pend_in  = esc_pend_ff;
      pend_byte_in = pend_byte_ff;
      pend_end_in  = pend_end_ff;
      crc_in       = crc_ff;
      fcs_hi_in    = fcs_hi_ff;
      if (load_ok) begin
         if (esc_pend_ff) begin
            out_valid_in = 1'b1;
            out_byte_in  = pend_byte_ff;
            out_end_in   = pend_end_ff;
            esc_pend_in  = 1'b0;
         end else if (pop_valid) begin
            out_valid_in = 1'b1;
            if (is_data) begin
               crc_in = crc_upd;
               if (need_esc) begin
                  out_byte_in  = ESC_OCTET;
                  out_end_in   = 1'b0;
                  esc_pend_in  = 1'b1;
                  pend_byte_in = sel_byte ^ ESC_XOR;
                  pend_end_in  = pop_op.last;
               end else begin
                  out_byte_in = sel_byte;
                  out_end_in  = pop_op.last;
               end
            end else begin
               out_byte_in = FLAG_OCTET;
               out_end_in  = pop_op.last;
            end
            if (pop_op.kind == OP_OPEN) begin
               crc_in = FCS_INIT;
            end
            if (pop_op.kind == OP_FCS_LO) begin
               fcs_hi_in = fcs_val[15:8];
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         esc_pend_ff  <= 1'b0;
         crc_ff       <= FCS_INIT;
      end else begin
         out_valid_ff <= out_valid_in;
         esc_pend_ff  <= esc_pend_in;
         crc_ff       <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_end_ff   <= out_end_in;
      pend_byte_ff <= pend_byte_in;
      pend_end_ff  <= pend_end_in;
      fcs_hi_ff    <= fcs_hi_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.run_end  = out_end_ff;

   // A held second octet only exists behind a shown escape octet
   `AHTF_ASSERT_IMP(a_pend_needs_out, clock, reset, esc_pend_ff, out_valid_ff,
      "pending octet without output")
   `AHTF_ASSERT_IMP(a_pend_shows_esc, clock, reset, esc_pend_ff,
      (out_byte_ff == ESC_OCTET) && !out_end_ff, "escape octet not shown")
   `AHTF_ASSERT_NEXT(a_open_inits_fcs, clock, reset, take_op && (pop_op.kind == OP_OPEN),
      crc_ff == FCS_INIT, "frame open did not reset FCS")

endmodule

`default_nettype wire

// ===== rtl/core/async_hdlc_tx_framer.sv =====
// Top level of the async HDLC transmit framer with FCS-16.
//
//   Channel  Dir  Handshake          Word
//   req      in   valid/ready        data_byte, first_byte, last_byte, protocol
//   rsp      out  valid/ready        out_byte, run_end
//   csr      in   csr_write_en only  csr_index, csr_wdata
//
// The back end sends one line octet per cycle while rsp is not stalled; a word
// causes one octet per plain byte, two per escaped byte, plus the flag and up to
// four header bytes on frame start and two FCS bytes and the flag on frame end.
// The front end expands a word into ops one per cycle, while the queue has room,
// into a queue of QDEPTH ops, so it takes the next word while the back end drains
// earlier octets. Reset is synchronous; it empties the queue and output register
// and sets the FCS to 0xffff. Either side may stall at any time without loss.
`timescale 1ns / 1ps
`default_nettype none

module async_hdlc_tx_framer
   import ahtf_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   ahtf_req_if.sink                  req,
   ahtf_rsp_if.source                rsp,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   ahtf_cfg_type cfg_ff, cfg_in;
   ahtf_op_type  push_op;
   logic         push_valid;
   logic         push_ready;
   ahtf_op_type  pop_op;
   logic         pop_valid;
   logic         pop_ready;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ESC_MAP:    cfg_in.esc_map = csr_wdata;
            CSR_ADDR_CTRL:  cfg_in.addr_ctrl_compress = csr_wdata[0];
            CSR_PROTO_COMP: cfg_in.proto_compress = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.esc_map            <= 32'hffff_ffff;
         cfg_ff.addr_ctrl_compress <= 1'b0;
         cfg_ff.proto_compress     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ahtf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .push_op    (push_op),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   ahtf_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_op    (push_op),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_op     (pop_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   ahtf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_op    (pop_op),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire
